@@ rtl/serial_cmd_motor_position_ctrl_unit_macros.svh @@
// Assertion macros for the serial command motor position controller.
// Included by the checker module; no other dependencies.
`ifndef SERIAL_CMD_MOTOR_POSITION_CTRL_UNIT_MACROS_SVH
`define SERIAL_CMD_MOTOR_POSITION_CTRL_UNIT_MACROS_SVH

// Checked only out of reset.
`define SCMPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scmpc assertion failed");

// Checked at every edge, reset included.
`define SCMPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scmpc assertion failed");

`endif

@@ rtl/scmpc_pkg.sv @@
// Shared types and constants for the serial command motor position controller.
// No dependencies.
`default_nettype none

package scmpc_pkg;

  localparam logic [7:0] StartByte    = 8'hFF;
  localparam logic [7:0] SpeedCodeMax = 8'd100;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgCentreCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepScale  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSpeedScale = 2'd2;

  localparam logic [7:0] CentreCodeRst = 8'd19;
  localparam logic [7:0] StepScaleRst  = 8'd40;
  localparam logic [9:0] SpeedScaleRst = 10'd655;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [15:0] count_up;
    logic [15:0] count_down;
  } in_t;

  typedef struct packed {
    logic        drive_negative;
    logic [15:0] drive_duty;
    logic        command_taken;
  } out_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_X     = 5'b00010,
    PH_Y     = 5'b00100,
    PH_SPEED = 5'b01000,
    PH_ESC   = 5'b10000
  } phase_e;

  // Classified work item passed from front to back.
  typedef struct packed {
    kind_e       kind;
    logic        negative;
    logic [15:0] disp;
    logic [15:0] speed;
    logic [15:0] count_up;
    logic [15:0] count_down;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/serial_cmd_motor_position_ctrl_unit.sv @@
// Path: an accepted input is written into the item queue, and the back end
// pops it into the output register. One item per cycle while neither side stalls;
// the item queue (QUEUE_DEPTH entries) lets either side stall alone.
// Reset: asynchronous, active low; clears frame parser, drive state and
// queue, and loads the configuration registers with their defaults.
`default_nettype none

module serial_cmd_motor_position_ctrl_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scmpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [scmpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire scmpc_pkg::in_t                 in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output scmpc_pkg::out_t                     out_data_o
);

  logic             q_full, q_push, q_pop, q_valid;
  scmpc_pkg::item_t q_in, q_out;

  scmpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  scmpc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  scmpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/scmpc_front.sv @@
// Front end: frame parser, configuration registers and command decode.
// Depends on scmpc_pkg.
`default_nettype none

module scmpc_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scmpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [scmpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire scmpc_pkg::in_t                 in_data_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output scmpc_pkg::item_t                    q_item_o
);

  scmpc_pkg::phase_e phase_q, phase_d;
  logic [7:0] held_y_q, held_y_d;
  logic [7:0] held_speed_q, held_speed_d;
  logic [7:0] centre_q;
  logic [7:0] step_scale_q;
  logic [9:0] speed_scale_q;

  logic        accept;
  logic        y_above;
  logic [7:0]  steps;
  logic [15:0] disp;
  logic [6:0]  code;
  logic [16:0] prod;
  logic [15:0] speed_sat;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q      <= scmpc_pkg::CentreCodeRst;
      step_scale_q  <= scmpc_pkg::StepScaleRst;
      speed_scale_q <= scmpc_pkg::SpeedScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scmpc_pkg::CfgCentreCode: centre_q      <= cfg_wdata_i[7:0];
        scmpc_pkg::CfgStepScale:  step_scale_q  <= cfg_wdata_i[7:0];
        scmpc_pkg::CfgSpeedScale: speed_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    y_above   = held_y_q > centre_q;
    steps     = y_above ? (held_y_q - centre_q) : (centre_q - held_y_q);
    disp      = {8'b0, steps} * {8'b0, step_scale_q};
    code      = (held_speed_q > scmpc_pkg::SpeedCodeMax) ?
                scmpc_pkg::SpeedCodeMax[6:0] : held_speed_q[6:0];
    prod      = {10'b0, code} * {7'b0, speed_scale_q};
    speed_sat = prod[16] ? 16'hFFFF : prod[15:0];
  end

  always_comb begin
    q_item_o.negative   = ~y_above;
    q_item_o.disp       = disp;
    q_item_o.speed      = (disp == 16'd0) ? 16'd0 : speed_sat;
    q_item_o.count_up   = in_data_i.count_up;
    q_item_o.count_down = in_data_i.count_down;
    if (in_data_i.operation) begin
      q_item_o.kind = scmpc_pkg::KIND_TICK;
    end else if (phase_q == scmpc_pkg::PH_ESC) begin
      q_item_o.kind = scmpc_pkg::KIND_CMD;
    end else begin
      q_item_o.kind = scmpc_pkg::KIND_BYTE;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    held_y_d     = held_y_q;
    held_speed_d = held_speed_q;
    if (accept && !in_data_i.operation) begin
      case (phase_q)
        scmpc_pkg::PH_HUNT: begin
          if (in_data_i.rx_byte == scmpc_pkg::StartByte) begin
            phase_d = scmpc_pkg::PH_X;
          end
        end
        scmpc_pkg::PH_X: phase_d = scmpc_pkg::PH_Y;
        scmpc_pkg::PH_Y: begin
          held_y_d = in_data_i.rx_byte;
          phase_d  = scmpc_pkg::PH_SPEED;
        end
        scmpc_pkg::PH_SPEED: begin
          held_speed_d = in_data_i.rx_byte;
          phase_d      = scmpc_pkg::PH_ESC;
        end
        default: phase_d = scmpc_pkg::PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= scmpc_pkg::PH_HUNT;
      held_y_q     <= 8'd0;
      held_speed_q <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      held_y_q     <= held_y_d;
      held_speed_q <= held_speed_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scmpc_queue.sv @@
// Small FIFO of classified items between front and back.
// Depends on scmpc_pkg.
`default_nettype none

module scmpc_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire scmpc_pkg::item_t item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output scmpc_pkg::item_t      item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  scmpc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/scmpc_back.sv @@
// Back end: position tracking, target and drive update, output register.
// Depends on scmpc_pkg.
`default_nettype none

module scmpc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire scmpc_pkg::item_t q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output scmpc_pkg::out_t       out_data_o
);

  logic        dir_q, dir_d;
  logic [15:0] target_q, target_d;
  logic [15:0] run_q, run_d;
  logic [15:0] duty_q, duty_d;
  logic        out_valid_q;
  scmpc_pkg::out_t out_q;

  logic        pos_dir;
  logic [15:0] pos;

  assign q_pop_o     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    pos_dir = (q_item_i.kind == scmpc_pkg::KIND_CMD) ? q_item_i.negative : dir_q;
    pos     = pos_dir ? (16'd0 - q_item_i.count_down) : q_item_i.count_up;

    dir_d    = dir_q;
    target_d = target_q;
    run_d    = run_q;
    duty_d   = duty_q;
    case (q_item_i.kind)
      scmpc_pkg::KIND_CMD: begin
        dir_d    = q_item_i.negative;
        target_d = q_item_i.negative ? (pos - q_item_i.disp) : (pos + q_item_i.disp);
        run_d    = q_item_i.speed;
        duty_d   = q_item_i.speed;
      end
      scmpc_pkg::KIND_TICK: begin
        if (pos == target_q) begin
          duty_d = 16'd0;
        end else begin
          dir_d  = $signed(pos) > $signed(target_q);
          duty_d = run_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      target_q    <= 16'd0;
      run_q       <= 16'd0;
      duty_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        dir_q       <= dir_d;
        target_q    <= target_d;
        run_q       <= run_d;
        duty_q      <= duty_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q.drive_negative <= dir_d;
      out_q.drive_duty     <= duty_d;
      out_q.command_taken  <= (q_item_i.kind == scmpc_pkg::KIND_CMD);
    end
  end

endmodule

`default_nettype wire

@@ rtl/scmpc_chk.sv @@
// Port-level checker for the motor position controller, bound to the top.
// Depends on scmpc_pkg and the macros header.
`default_nettype none
`include "serial_cmd_motor_position_ctrl_unit_macros.svh"

module scmpc_chk (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire scmpc_pkg::in_t  in_data_i,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire scmpc_pkg::out_t out_data_o
);

  `SCMPC_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)
  `SCMPC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `SCMPC_ASSERT(a_fresh_result_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
  `SCMPC_ASSERT(a_taken_from_byte, clk_i, rst_ni, $rose(out_valid_o) && out_data_o.command_taken |-> $past(!in_data_i.operation, 2))

endmodule

bind serial_cmd_motor_position_ctrl_unit scmpc_chk u_scmpc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ tb/sv/serial_cmd_motor_position_ctrl_unit_test.sv @@
// Self-checking testbench for serial_cmd_motor_position_ctrl_unit: command frames and control
// ticks against a cycle-free predictor of the drive outputs. Depends on scmpc_pkg and the RTL.
`timescale 1ns / 100ps

module serial_cmd_motor_position_ctrl_unit_test;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;
  localparam logic [scmpc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int DrainCycles = 4;
  localparam int CycleLimit = 200000;
  localparam int SettingEvery = 75;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [scmpc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [scmpc_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  scmpc_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  scmpc_pkg::out_t out_data_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int setting_no = 0;
  int items_sent = 0;

  // drive state as the block should hold it
  scmpc_pkg::phase_e frame_pos = scmpc_pkg::PH_HUNT;
  logic [7:0] held_y = '0;
  logic [7:0] held_speed = '0;
  logic drive_neg = 1'b0;
  logic [15:0] target_pos = '0;
  logic [15:0] run_duty = '0;
  logic [15:0] duty_now = '0;
  logic [7:0] reg_centre = scmpc_pkg::CentreCodeRst;
  logic [7:0] reg_step = scmpc_pkg::StepScaleRst;
  logic [9:0] reg_speed = scmpc_pkg::SpeedScaleRst;

  scmpc_pkg::out_t drive_expect_q[$];

  serial_cmd_motor_position_ctrl_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("serial_cmd_motor_position_ctrl_unit_test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [15:0] position_of(input logic neg, input logic [15:0] up,
                                               input logic [15:0] down);
    return neg ? (16'd0 - down) : up;
  endfunction

  function automatic scmpc_pkg::out_t drive_after(input scmpc_pkg::in_t xfer);
    scmpc_pkg::out_t res;
    logic [7:0] steps;
    logic [7:0] code;
    logic [15:0] disp;
    logic [15:0] pos;
    logic [16:0] prod;
    res.command_taken = 1'b0;
    if (xfer.operation == OpTick) begin
      pos = position_of(drive_neg, xfer.count_up, xfer.count_down);
      if (pos == target_pos) begin
        duty_now = '0;
      end else begin
        drive_neg = ($signed(pos) > $signed(target_pos));
        duty_now = run_duty;
      end
    end else begin
      case (frame_pos)
        scmpc_pkg::PH_HUNT: begin
          if (xfer.rx_byte == scmpc_pkg::StartByte) frame_pos = scmpc_pkg::PH_X;
        end
        scmpc_pkg::PH_X: frame_pos = scmpc_pkg::PH_Y;
        scmpc_pkg::PH_Y: begin
          held_y = xfer.rx_byte;
          frame_pos = scmpc_pkg::PH_SPEED;
        end
        scmpc_pkg::PH_SPEED: begin
          held_speed = xfer.rx_byte;
          frame_pos = scmpc_pkg::PH_ESC;
        end
        scmpc_pkg::PH_ESC: begin
          if (held_y > reg_centre) begin
            drive_neg = 1'b0;
            steps = held_y - reg_centre;
          end else begin
            drive_neg = 1'b1;
            steps = reg_centre - held_y;
          end
          disp = 16'(steps) * 16'(reg_step);
          code = (held_speed > scmpc_pkg::SpeedCodeMax) ? scmpc_pkg::SpeedCodeMax : held_speed;
          prod = 17'(code) * 17'(reg_speed);
          run_duty = (prod > 17'h0FFFF) ? 16'hFFFF : prod[15:0];
          if (disp == 16'd0) run_duty = '0;
          pos = position_of(drive_neg, xfer.count_up, xfer.count_down);
          target_pos = drive_neg ? (pos - disp) : (pos + disp);
          duty_now = run_duty;
          frame_pos = scmpc_pkg::PH_HUNT;
          res.command_taken = 1'b1;
        end
        default: frame_pos = scmpc_pkg::PH_HUNT;
      endcase
    end
    res.drive_negative = drive_neg;
    res.drive_duty = duty_now;
    return res;
  endfunction

  function automatic scmpc_pkg::in_t pack_item(input logic op, input logic [7:0] rx,
                                               input logic [15:0] up, input logic [15:0] down);
    scmpc_pkg::in_t xfer;
    xfer.operation = op;
    xfer.rx_byte = rx;
    xfer.count_up = up;
    xfer.count_down = down;
    return xfer;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count < 40) begin
      $display("mismatch on %s at cycle %0d: got %0h, want %0h", what, cycle_count, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    scmpc_pkg::out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("transfer with none pending", 16'(out_data_o), '0);
      end else begin
        want = drive_expect_q.pop_front();
        if (out_data_o.drive_negative !== want.drive_negative)
          report_mismatch("drive_negative", 16'(out_data_o.drive_negative),
                          16'(want.drive_negative));
        if (out_data_o.drive_duty !== want.drive_duty)
          report_mismatch("drive_duty", out_data_o.drive_duty, want.drive_duty);
        if (out_data_o.command_taken !== want.command_taken)
          report_mismatch("command_taken", 16'(out_data_o.command_taken),
                          16'(want.command_taken));
      end
    end
  end

  task automatic send_item(input scmpc_pkg::in_t xfer);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= xfer;
    do @(posedge clk_i); while (in_stall_o);
    drive_expect_q.push_back(drive_after(xfer));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [scmpc_pkg::CfgIdxW-1:0] idx,
                           input logic [scmpc_pkg::CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      scmpc_pkg::CfgCentreCode: reg_centre = value[7:0];
      scmpc_pkg::CfgStepScale: reg_step = value[7:0];
      scmpc_pkg::CfgSpeedScale: reg_speed = value;
      default: ;
    endcase
  endtask

  task automatic apply_next_setting();
    wait_drained();
    case (setting_no)
      0: begin
        write_reg(scmpc_pkg::CfgCentreCode, 10'd0);
        write_reg(scmpc_pkg::CfgStepScale, 10'd255);
        write_reg(scmpc_pkg::CfgSpeedScale, 10'd0);
        write_reg(CfgUnused, '1);
      end
      1: begin
        write_reg(scmpc_pkg::CfgCentreCode, 10'd255);
        write_reg(scmpc_pkg::CfgStepScale, 10'd0);
        write_reg(scmpc_pkg::CfgSpeedScale, 10'd655);
      end
      2: begin
        // wide scale: speed product saturates
        write_reg(scmpc_pkg::CfgCentreCode, 10'd128);
        write_reg(scmpc_pkg::CfgStepScale, 10'd1);
        write_reg(scmpc_pkg::CfgSpeedScale, 10'd1023);
      end
      default: begin
        write_reg(scmpc_pkg::CfgCentreCode, 10'($urandom_range(255)));
        write_reg(scmpc_pkg::CfgStepScale, 10'($urandom_range(255)));
        write_reg(scmpc_pkg::CfgSpeedScale, ($urandom_range(7) == 0) ? 10'd1023 :
                                            10'($urandom_range(655)));
      end
    endcase
    setting_no++;
  endtask

  // counts chosen so the position often lands on or next to the target
  task automatic send_tick();
    scmpc_pkg::in_t xfer;
    logic [15:0] pos;
    xfer = pack_item(OpTick, 8'($urandom), 16'($urandom), 16'($urandom));
    case ($urandom_range(2))
      0: pos = target_pos;
      1: pos = target_pos + 16'($urandom_range(6)) - 16'd3;
      default: pos = 16'($urandom);
    endcase
    if (drive_neg) xfer.count_down = 16'd0 - pos;
    else xfer.count_up = pos;
    send_item(xfer);
  endtask

  task automatic send_frame(input logic [7:0] y_code, input logic [7:0] speed_code);
    logic [7:0] body [5];
    body = '{scmpc_pkg::StartByte, 8'($urandom), y_code, speed_code, 8'($urandom)};
    foreach (body[k]) begin
      if (k != 0 && $urandom_range(4) == 0) send_tick();
      send_item(pack_item(OpByte, body[k], 16'($urandom), 16'($urandom)));
    end
  endtask

  task automatic test_directed_frames();
    scmpc_pkg::in_t seq[$];
    send_idle_pct = 17;
    recv_idle_pct = 65;
    seq = '{
      pack_item(OpTick, 8'hFF, 16'h0000, 16'hFFFF),
      pack_item(OpByte, 8'h00, 16'hFFFF, 16'hFFFF),
      // start byte repeated inside the frame is data; speed byte clipped
      pack_item(OpByte, scmpc_pkg::StartByte, 16'h0000, 16'h0000),
      pack_item(OpByte, scmpc_pkg::StartByte, 16'h0000, 16'h0000),
      pack_item(OpByte, scmpc_pkg::StartByte, 16'h0000, 16'h0000),
      pack_item(OpByte, scmpc_pkg::StartByte, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h00, 16'hFFFF, 16'h0000),
      pack_item(OpTick, 8'h00, 16'h8000, 16'h0000),
      pack_item(OpTick, 8'h00, 16'h24DF, 16'h0000),
      // minus direction, zero speed
      pack_item(OpByte, scmpc_pkg::StartByte, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h00, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h00, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h00, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h7F, 16'h0000, 16'hFFFF),
      pack_item(OpTick, 8'h00, 16'hFFFF, 16'h0000),
      // y at centre: no displacement, speed forced to zero
      pack_item(OpByte, scmpc_pkg::StartByte, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h07, 16'h0000, 16'h0000),
      pack_item(OpByte, scmpc_pkg::CentreCodeRst, 16'h0000, 16'h0000),
      pack_item(OpByte, scmpc_pkg::SpeedCodeMax, 16'h0000, 16'h0000),
      pack_item(OpByte, 8'h01, 16'h1234, 16'h0000),
      pack_item(OpTick, 8'h00, 16'h1235, 16'h0000)
    };
    foreach (seq[k]) send_item(seq[k]);
  endtask

  task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
    int first;
    int last_setting;
    logic [7:0] y_code;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_sent;
    last_setting = items_sent - SettingEvery;
    while (items_sent - first < items) begin
      if (items_sent - last_setting >= SettingEvery) begin
        apply_next_setting();
        last_setting = items_sent;
      end
      case ($urandom_range(9))
        0: send_item(pack_item(OpByte,
                               ($urandom_range(3) == 0) ? scmpc_pkg::StartByte : 8'($urandom),
                               16'($urandom), 16'($urandom)));
        1, 2, 3: send_tick();
        default: begin
          if ($urandom_range(3) == 0) y_code = 8'($urandom);
          else y_code = reg_centre + 8'($urandom_range(10)) - 8'd5;
          send_frame(y_code, 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= scmpc_pkg::CfgCentreCode;
    cfg_wdata_i <= '0;
    out_stall_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_random_traffic(300, 17, 65);
    test_random_traffic(300, 65, 17);
    test_random_traffic(300, 0, 0);
    wait_drained();
    if (fail_count == 0) begin
      $display("serial_cmd_motor_position_ctrl_unit_test passed");
    end else begin
      $display("serial_cmd_motor_position_ctrl_unit_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/scmpc_pkg.sv
rtl/scmpc_front.sv
rtl/scmpc_queue.sv
rtl/scmpc_back.sv
rtl/serial_cmd_motor_position_ctrl_unit.sv
rtl/scmpc_chk.sv
tb/sv/serial_cmd_motor_position_ctrl_unit_test.sv
